// ===== rtl/core/tre_pkg.sv =====
// tre_pkg: shared types and constants of the Targa run-length packet encoder.
// Used by tre_csr, tre_ctrl, tre_dpath and tga_rle_packet_encoder_top.
// No dependencies.
package tre_pkg;

   // Longest packet in pixels (Targa limit), default for the top level
   localparam int MAX_PACKET_DEF = 128;
   // Most results one request may release
   localparam int MAX_RESULTS = 64;
   // A raw packet this long that meets an equal row-end pixel swallows it
   localparam int FOLD_COUNT = 2 * MAX_RESULTS - 1;

   // Header flag of a run packet
   localparam logic RUN_FLAG = 1'b1;

   // Register map: index is paddr bit 2
   localparam int ADDR_W = 3;
   localparam logic REG_COMPRESS = 1'b0;
   localparam logic REG_BPP = 1'b1;

   // Register reset values and decode
   localparam logic COMPRESS_RESET = 1'b1;
   localparam logic [2:0] BPP_RESET = 3'd3;
   localparam logic [2:0] BPP_RGBA = 3'd4;

   // One stored pixel, red in the low byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Pending count update
   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_CLR  = 2'd1,
      CNT_ONE  = 2'd2,
      CNT_INC  = 2'd3
   } cnt_op_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic compress;
      logic rgba;
      logic clear;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       wr_mem;
      logic       first_ld;
      logic       run_ld;
      logic       run_val;
      cnt_op_type cnt_op;
      logic       ld_a;
      logic       a_run;
      logic       a_len_n1;
      logic       ld_b;
      logic       rd;
      logic       emit;
      logic       last_of_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic compress;
      logic run;
      logic n_zero;
      logic n_one;
      logic eq;
      logic row_end;
      logic n1_ge_max;
      logic n_ge_fold;
      logic pkt_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/tre_csr.sv =====
// tre_csr: APB register block (compress enable, bytes per pixel).
// Depends on tre_pkg.
module tre_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tre_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output tre_pkg::cfg_type             cfg
);

   logic       compress_ff, compress_in;
   logic [2:0] bpp_ff, bpp_in;
   logic       wr;
   logic       idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[2];

   // register writes
   always_comb begin
      compress_in = compress_ff;
      bpp_in      = bpp_ff;
      if (wr) begin
         case (idx)
            tre_pkg::REG_COMPRESS: compress_in = csr_pwdata[0];
            tre_pkg::REG_BPP:      bpp_in = csr_pwdata[2:0];
            default:               bpp_in = bpp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_ff <= tre_pkg::COMPRESS_RESET;
         bpp_ff      <= tre_pkg::BPP_RESET;
      end else begin
         compress_ff <= compress_in;
         bpp_ff      <= bpp_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         tre_pkg::REG_COMPRESS: csr_prdata = {31'b0, compress_ff};
         tre_pkg::REG_BPP:      csr_prdata = {29'b0, bpp_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // any write restarts packet state
   assign cfg.compress = compress_ff;
   assign cfg.rgba     = (bpp_ff == tre_pkg::BPP_RGBA);
   assign cfg.clear    = wr;

endmodule

// ===== rtl/core/tre_ctrl.sv =====
// tre_ctrl: controller of the packet encoder; decides each request's packets
// and sequences their results. Depends on tre_pkg; drives tre_dpath.
module tre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tre_pkg::status_type  status,
   output tre_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECIDE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      b_pend_ff, b_pend_in;
   logic      a_en, b_en;
   logic      close;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.cnt_op = tre_pkg::CNT_HOLD;
      state_in   = state_ff;
      b_pend_in  = b_pend_ff;
      a_en       = 1'b0;
      b_en       = 1'b0;
      close      = status.n1_ge_max || status.row_end;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.compress) begin
               // pass-through pixel, no header
               b_en = 1'b1;
            end else if (status.run) begin
               if (status.n_zero) begin
                  // open a run check
                  cmd.first_ld = 1'b1;
                  cmd.cnt_op   = status.row_end ? tre_pkg::CNT_CLR : tre_pkg::CNT_ONE;
                  b_en         = status.row_end;
               end else if (status.eq) begin
                  // run grows; closes at the limit or row end
                  if (close) begin
                     a_en         = 1'b1;
                     cmd.a_run    = 1'b1;
                     cmd.a_len_n1 = 1'b1;
                     cmd.cnt_op   = tre_pkg::CNT_CLR;
                     cmd.run_ld   = 1'b1;
                     cmd.run_val  = status.row_end;
                  end else begin
                     cmd.cnt_op = tre_pkg::CNT_INC;
                  end
               end else if (!status.n_one) begin
                  // run broken: run packet, pixel opens a raw packet
                  a_en         = 1'b1;
                  cmd.a_run    = 1'b1;
                  cmd.first_ld = 1'b1;
                  cmd.run_ld   = 1'b1;
                  cmd.run_val  = status.row_end;
                  cmd.cnt_op   = status.row_end ? tre_pkg::CNT_CLR : tre_pkg::CNT_ONE;
                  b_en         = status.row_end;
               end else begin
                  // single pixel then a different one: raw packet of two
                  cmd.wr_mem = 1'b1;
                  if (close) begin
                     a_en         = 1'b1;
                     cmd.a_len_n1 = 1'b1;
                     cmd.cnt_op   = tre_pkg::CNT_CLR;
                  end else begin
                     cmd.cnt_op  = tre_pkg::CNT_INC;
                     cmd.run_ld  = 1'b1;
                     cmd.run_val = 1'b0;
                  end
               end
            end else begin
               if (status.n_zero) begin
                  // raw packet straight after a run at its limit
                  cmd.first_ld = 1'b1;
                  cmd.cnt_op   = status.row_end ? tre_pkg::CNT_CLR : tre_pkg::CNT_ONE;
                  b_en         = status.row_end;
                  cmd.run_ld   = status.row_end;
                  cmd.run_val  = 1'b1;
               end else if (status.eq && status.row_end && status.n_ge_fold) begin
                  // equal pixel at row end joins a full-length raw packet
                  cmd.wr_mem   = 1'b1;
                  a_en         = 1'b1;
                  cmd.a_len_n1 = 1'b1;
                  cmd.cnt_op   = tre_pkg::CNT_CLR;
                  cmd.run_ld   = 1'b1;
                  cmd.run_val  = 1'b1;
               end else if (status.eq) begin
                  // equal pixel closes the raw packet and starts a run check
                  a_en         = 1'b1;
                  cmd.first_ld = 1'b1;
                  cmd.run_ld   = 1'b1;
                  cmd.run_val  = 1'b1;
                  cmd.cnt_op   = status.row_end ? tre_pkg::CNT_CLR : tre_pkg::CNT_ONE;
                  b_en         = status.row_end;
               end else begin
                  // raw packet grows
                  cmd.wr_mem = 1'b1;
                  if (close) begin
                     a_en         = 1'b1;
                     cmd.a_len_n1 = 1'b1;
                     cmd.cnt_op   = tre_pkg::CNT_CLR;
                     cmd.run_ld   = 1'b1;
                     cmd.run_val  = 1'b1;
                  end else begin
                     cmd.cnt_op = tre_pkg::CNT_INC;
                  end
               end
            end
            cmd.ld_a  = a_en;
            cmd.ld_b  = b_en && !a_en;
            b_pend_in = a_en && b_en;
            state_in  = (a_en || b_en) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit         = 1'b1;
               cmd.last_of_step = status.pkt_last && !b_pend_ff;
               if (!status.pkt_last) begin
                  state_in = ST_READ;
               end else if (b_pend_ff) begin
                  // trailing one-pixel packet
                  cmd.ld_b  = 1'b1;
                  b_pend_in = 1'b0;
                  state_in  = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in  = ST_IDLE;
            b_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         b_pend_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         b_pend_ff <= b_pend_in;
      end
   end

`ifndef SYNTHESIS
   // no trailing packet may be left over once the request is done
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !b_pend_ff)
      else $error("trailing packet pending in idle");

   // a captured request is decided in the next cycle
   a_capture_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_DECIDE))
      else $error("captured request not decided");
`endif

endmodule

// ===== rtl/core/tre_dpath.sv =====
// tre_dpath: pixel capture, packet state, pending pixel memory, result
// assembly and output register. Depends on tre_pkg; controlled by tre_ctrl.
module tre_dpath #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tre_pkg::cfg_type     cfg,
   input  tre_pkg::cmd_type     cmd,
   output tre_pkg::status_type  status,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  logic [7:0]           req_alpha,
   input  logic                 req_row_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_has_header,
   output logic [7:0]           rsp_header_byte,
   output logic [1:0]           rsp_pixel_count,
   output logic [7:0]           rsp_first_blue,
   output logic [7:0]           rsp_first_green,
   output logic [7:0]           rsp_first_red,
   output logic [7:0]           rsp_first_alpha,
   output logic [7:0]           rsp_second_blue,
   output logic [7:0]           rsp_second_green,
   output logic [7:0]           rsp_second_red,
   output logic [7:0]           rsp_second_alpha,
   output logic                 rsp_packet_end
);

   localparam int CW = $clog2(MAX_PACKET + 1);
   localparam int AW = $clog2(MAX_PACKET);

   // captured request
   tre_pkg::pixel_type px_ff;
   logic               end_ff;

   // packet state
   logic [CW-1:0]      count_ff, count_in;
   tre_pkg::pixel_type first_ff, first_in;
   logic               run_ff, run_in;

   // pending pixels (entry 0 lives in first_ff)
   tre_pkg::pixel_type mem [MAX_PACKET];
   tre_pkg::pixel_type rd0_ff, rd1_ff;

   // packet being emitted
   logic [7:0]         hdr_ff;
   logic               hdr_en_ff;
   logic [CW-1:0]      elen_ff;
   logic [CW-1:0]      pos_ff;
   tre_pkg::pixel_type p0_ff;

   // output register
   logic               rsp_valid_ff;
   logic               has_header_ff;
   logic [7:0]         header_ff;
   logic [1:0]         pix_cnt_ff;
   tre_pkg::pixel_type out0_ff, out1_ff;
   logic               pkt_end_ff;

   logic [CW:0]        count_p1;
   logic [CW-1:0]      len_a, len_m1, rem, pos_p1;
   logic [AW-1:0]      addr0, addr1;
   logic               two, out_free, has_header;
   tre_pkg::pixel_type pix0, pix1;

   // request capture, alpha kept only for RGBA
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff.red   <= req_red;
         px_ff.green <= req_green;
         px_ff.blue  <= req_blue;
         px_ff.alpha <= cfg.rgba ? req_alpha : 8'd0;
         end_ff      <= req_row_end;
      end
   end

   // status
   assign count_p1 = {1'b0, count_ff} + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rem      = elen_ff - pos_ff;
   assign two      = (rem > CW'(1));

   assign status.compress  = cfg.compress;
   assign status.run       = run_ff;
   assign status.n_zero    = (count_ff == '0);
   assign status.n_one     = (count_ff == CW'(1));
   assign status.eq        = (px_ff == first_ff);
   assign status.row_end   = end_ff;
   assign status.n1_ge_max = (count_p1 >= (CW + 1)'(MAX_PACKET));
   assign status.n_ge_fold = (32'(count_ff) >= 32'(tre_pkg::FOLD_COUNT));
   assign status.pkt_last  = (rem <= CW'(2));
   assign status.out_free  = out_free;

   // packet state update
   always_comb begin
      case (cmd.cnt_op)
         tre_pkg::CNT_CLR: count_in = '0;
         tre_pkg::CNT_ONE: count_in = CW'(1);
         tre_pkg::CNT_INC: count_in = count_p1[CW-1:0];
         default:          count_in = count_ff;
      endcase
      first_in = cmd.first_ld ? px_ff : first_ff;
      run_in   = cmd.run_ld ? cmd.run_val : run_ff;
      if (cfg.clear) begin
         count_in = '0;
         first_in = '0;
         run_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         run_ff   <= 1'b1;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         run_ff   <= run_in;
      end
   end

   // pending memory: one write, two registered reads
   assign pos_p1 = pos_ff + CW'(1);
   assign addr0  = pos_ff[AW-1:0];
   assign addr1  = (pos_p1 >= CW'(MAX_PACKET)) ? '0 : pos_p1[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_mem) mem[count_ff[AW-1:0]] <= px_ff;
      if (cmd.rd) begin
         rd0_ff <= mem[addr0];
         rd1_ff <= mem[addr1];
      end
   end

   // packet descriptor: header and length
   assign len_a  = cmd.a_len_n1 ? count_p1[CW-1:0] : count_ff;
   assign len_m1 = len_a - CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.ld_a) begin
         hdr_ff    <= {cmd.a_run && tre_pkg::RUN_FLAG, 7'(len_m1)};
         hdr_en_ff <= 1'b1;
         elen_ff   <= cmd.a_run ? CW'(1) : len_a;
         pos_ff    <= '0;
         p0_ff     <= first_ff;
      end else if (cmd.ld_b) begin
         hdr_ff    <= 8'd0;
         hdr_en_ff <= cfg.compress;
         elen_ff   <= CW'(1);
         pos_ff    <= '0;
         p0_ff     <= px_ff;
      end else if (cmd.emit) begin
         pos_ff <= pos_ff + CW'(2);
      end
   end

   // result assembly
   assign has_header = hdr_en_ff && (pos_ff == '0);
   assign pix0       = (pos_ff == '0) ? p0_ff : rd0_ff;
   assign pix1       = two ? rd1_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         has_header_ff <= has_header;
         header_ff     <= has_header ? hdr_ff : 8'd0;
         pix_cnt_ff    <= two ? 2'd2 : 2'd1;
         out0_ff       <= pix0;
         out1_ff       <= pix1;
         pkt_end_ff    <= cmd.last_of_step;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_header   = has_header_ff;
   assign rsp_header_byte  = header_ff;
   assign rsp_pixel_count  = pix_cnt_ff;
   assign rsp_first_blue   = out0_ff.blue;
   assign rsp_first_green  = out0_ff.green;
   assign rsp_first_red    = out0_ff.red;
   assign rsp_first_alpha  = out0_ff.alpha;
   assign rsp_second_blue  = out1_ff.blue;
   assign rsp_second_green = out1_ff.green;
   assign rsp_second_red   = out1_ff.red;
   assign rsp_second_alpha = out1_ff.alpha;
   assign rsp_packet_end   = pkt_end_ff;

`ifndef SYNTHESIS
   // a result is only built from pixels inside the current packet
   a_pos_in_packet: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (pos_ff < elen_ff))
      else $error("result past end of packet");

   // pending count never reaches the packet limit between requests
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_p1 <= (CW + 1)'(MAX_PACKET))
      else $error("pending count over packet limit");
`endif

endmodule

// ===== rtl/core/tga_rle_packet_encoder_top.sv =====
// tga_rle_packet_encoder_top: Targa run-length packet encoder, top level.
// Depends on tre_pkg, tre_csr, tre_ctrl and tre_dpath.
//
// Takes one RGB(A) pixel per request, with a row-end flag, and returns Targa
// packet data in B,G,R(,A) order, up to two pixels per result; the first
// result of a packet carries its header (bit 7 set for a run, low bits length
// minus one) and the last result of a request is marked with packet_end. With
// compression off every pixel comes back at once as one headerless result.
// Raw packets are held in a pending memory of MAX_PACKET pixels and released
// only when they close, so most requests give no result. A request passes
// through capture and a packet decision, then each result it releases through
// a pending-memory read and an output register load, and any output stall
// holds it; the single read stage of the pending memory paces the results.
// Results wait in an output register while the next request is taken. A
// write to either register drops any pending pixels; there is no clearing
// pass after reset.
module tga_rle_packet_encoder_top #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   input  logic [7:0]                  req_alpha,
   input  logic                        req_row_end,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_has_header,
   output logic [7:0]                  rsp_header_byte,
   output logic [1:0]                  rsp_pixel_count,
   output logic [7:0]                  rsp_first_blue,
   output logic [7:0]                  rsp_first_green,
   output logic [7:0]                  rsp_first_red,
   output logic [7:0]                  rsp_first_alpha,
   output logic [7:0]                  rsp_second_blue,
   output logic [7:0]                  rsp_second_green,
   output logic [7:0]                  rsp_second_red,
   output logic [7:0]                  rsp_second_alpha,
   output logic                        rsp_packet_end,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tre_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   tre_pkg::cfg_type    cfg;
   tre_pkg::cmd_type    cmd;
   tre_pkg::status_type status;

   // registers
   tre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // controller
   tre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tre_dpath #(
      .MAX_PACKET (MAX_PACKET)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .req_row_end      (req_row_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_header   (rsp_has_header),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_first_blue   (rsp_first_blue),
      .rsp_first_green  (rsp_first_green),
      .rsp_first_red    (rsp_first_red),
      .rsp_first_alpha  (rsp_first_alpha),
      .rsp_second_blue  (rsp_second_blue),
      .rsp_second_green (rsp_second_green),
      .rsp_second_red   (rsp_second_red),
      .rsp_second_alpha (rsp_second_alpha),
      .rsp_packet_end   (rsp_packet_end)
   );

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for tga_rle_packet_encoder_top, the Targa run-length encoder.
// Depends on tre_pkg and the encoder RTL. A packet predictor checks every result in order.
// Directed cases come first, then random rows under several register settings.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;

   // One result word as the encoder presents it
   typedef struct packed {
      logic               has_header;
      logic [7:0]         header_byte;
      logic [1:0]         pixel_count;
      tre_pkg::pixel_type first_px;
      tre_pkg::pixel_type second_px;
      logic               packet_end;
   } packet_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_alpha = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_has_header;
   logic [7:0]  rsp_header_byte;
   logic [1:0]  rsp_pixel_count;
   logic [7:0]  rsp_first_blue, rsp_first_green, rsp_first_red, rsp_first_alpha;
   logic [7:0]  rsp_second_blue, rsp_second_green, rsp_second_red, rsp_second_alpha;
   logic        rsp_packet_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [tre_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state
   tre_pkg::pixel_type pend_store [tre_pkg::MAX_PACKET_DEF];
   int                 pend_cnt = 0;
   tre_pkg::pixel_type lead_px = '0;
   logic               run_check = 1'b1;
   logic               cfg_compress = tre_pkg::COMPRESS_RESET;
   logic [2:0]         cfg_bpp = tre_pkg::BPP_RESET;
   packet_word_type    step_words[$];
   packet_word_type    expected_words[$];

   int   error_count = 0;
   logic gaps_on = 1'b1;
   int   stall_left = 0;
   int   idle_cycles = 0;

   tga_rle_packet_encoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .req_row_end      (req_row_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_header   (rsp_has_header),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_first_blue   (rsp_first_blue),
      .rsp_first_green  (rsp_first_green),
      .rsp_first_red    (rsp_first_red),
      .rsp_first_alpha  (rsp_first_alpha),
      .rsp_second_blue  (rsp_second_blue),
      .rsp_second_green (rsp_second_green),
      .rsp_second_red   (rsp_second_red),
      .rsp_second_alpha (rsp_second_alpha),
      .rsp_packet_end   (rsp_packet_end),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic tre_pkg::pixel_type mk_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                                logic [7:0] a);
      tre_pkg::pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.alpha = a;
      return p;
   endfunction

   function automatic tre_pkg::pixel_type rand_px();
      return tre_pkg::pixel_type'($urandom);
   endfunction

   // Random pixel guaranteed to differ from the given one
   function automatic tre_pkg::pixel_type differ_px(tre_pkg::pixel_type ref_px);
      tre_pkg::pixel_type p;
      p = rand_px();
      if (p == ref_px) p.blue[0] = ~p.blue[0];
      return p;
   endfunction

   // Split one packet into result words; header rides on the first word
   function automatic void push_packet(logic [7:0] hdr, logic from_store,
                                       tre_pkg::pixel_type lone, int n);
      packet_word_type w;
      int i;
      int cnt;
      i = 0;
      while (i < n && step_words.size() < tre_pkg::MAX_RESULTS) begin
         w = '0;
         cnt = (n - i >= 2) ? 2 : 1;
         w.has_header = (i == 0);
         w.header_byte = (i == 0) ? hdr : 8'h00;
         w.pixel_count = 2'(cnt);
         w.first_px = from_store ? pend_store[i] : lone;
         if (cnt == 2) w.second_px = pend_store[i + 1];
         step_words.push_back(w);
         i += cnt;
      end
   endfunction

   function automatic void store_pixel(tre_pkg::pixel_type p);
      if (pend_cnt < tre_pkg::MAX_PACKET_DEF) pend_store[pend_cnt] = p;
      pend_cnt++;
   endfunction

   function automatic logic [7:0] run_header(int n);
      return {tre_pkg::RUN_FLAG, 7'(n - 1)};
   endfunction

   function automatic logic [7:0] raw_header(int n);
      return {1'b0, 7'(n - 1)};
   endfunction

   // Packet predictor: advance on one accepted pixel, queue the words it releases
   function automatic void encode_pixel(tre_pkg::pixel_type in_px, logic row_end);
      tre_pkg::pixel_type p;
      packet_word_type w;
      int n;
      p = in_px;
      if (cfg_bpp != tre_pkg::BPP_RGBA) p.alpha = 8'h00;
      step_words.delete();
      n = pend_cnt;
      if (!cfg_compress) begin
         // plain pixels, no header
         w = '0;
         w.pixel_count = 2'd1;
         w.first_px = p;
         step_words.push_back(w);
      end else if (run_check) begin
         if (n == 0) begin
            lead_px = p;
            pend_cnt = 1;
            if (row_end) begin
               push_packet(8'h00, 1'b0, p, 1);
               pend_cnt = 0;
            end
         end else if (p == lead_px) begin
            n++;
            pend_cnt = n;
            if (n >= tre_pkg::MAX_PACKET_DEF || row_end) begin
               push_packet(run_header(n), 1'b0, lead_px, 1);
               pend_cnt = 0;
               run_check = row_end;
            end
         end else if (n > 1) begin
            // run closed by a different pixel, which opens a raw packet
            push_packet(run_header(n), 1'b0, lead_px, 1);
            lead_px = p;
            pend_store[0] = p;
            pend_cnt = 1;
            run_check = 1'b0;
            if (row_end) begin
               push_packet(8'h00, 1'b0, p, 1);
               pend_cnt = 0;
               run_check = 1'b1;
            end
         end else begin
            pend_store[0] = lead_px;
            pend_store[1] = p;
            pend_cnt = 2;
            run_check = 1'b0;
            if (pend_cnt >= tre_pkg::MAX_PACKET_DEF || row_end) begin
               push_packet(raw_header(2), 1'b1, p, 2);
               pend_cnt = 0;
               run_check = 1'b1;
            end
         end
      end else begin
         if (n == 0) begin
            lead_px = p;
            pend_store[0] = p;
            pend_cnt = 1;
            if (row_end) begin
               push_packet(8'h00, 1'b0, p, 1);
               pend_cnt = 0;
               run_check = 1'b1;
            end
         end else if (p == lead_px) begin
            if (row_end && (n + 1) / 2 + 1 > tre_pkg::MAX_RESULTS) begin
               // full-length raw packet swallows the equal row-end pixel
               store_pixel(p);
               n = (pend_cnt > tre_pkg::MAX_PACKET_DEF) ? tre_pkg::MAX_PACKET_DEF : pend_cnt;
               push_packet(raw_header(n), 1'b1, p, n);
               pend_cnt = 0;
               run_check = 1'b1;
            end else begin
               if (n > tre_pkg::MAX_PACKET_DEF) n = tre_pkg::MAX_PACKET_DEF;
               push_packet(raw_header(n), 1'b1, p, n);
               lead_px = p;
               pend_cnt = 1;
               run_check = 1'b1;
               if (row_end) begin
                  push_packet(8'h00, 1'b0, p, 1);
                  pend_cnt = 0;
               end
            end
         end else begin
            store_pixel(p);
            n = pend_cnt;
            if (n >= tre_pkg::MAX_PACKET_DEF || row_end) begin
               if (n > tre_pkg::MAX_PACKET_DEF) n = tre_pkg::MAX_PACKET_DEF;
               push_packet(raw_header(n), 1'b1, p, n);
               pend_cnt = 0;
               run_check = 1'b1;
            end
         end
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].packet_end = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   // Send one pixel request, with an occasional gap before it
   task automatic send_pixel(tre_pkg::pixel_type p, logic row_end);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= p.red;
      req_green <= p.green;
      req_blue <= p.blue;
      req_alpha <= p.alpha;
      req_row_end <= row_end;
      do @(posedge clock); while (req_stall);
      encode_pixel(p, row_end);
   endtask

   // Stop sending, let every expected word arrive, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      // bus idle between accesses
      @(posedge clock);
   endtask

   task automatic check_register(logic idx, logic [31:0] want);
      logic [31:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got !== want) begin
         $error("register %0d readback: expected %0h, got %0h", idx, want, got);
         error_count++;
      end
   endtask

   // Register write on an idle block; the write drops any pending pixels
   task automatic set_register(logic idx, logic [31:0] value);
      logic [31:0] unused;
      wait_drained();
      csr_access(1'b1, idx, value, unused);
      if (idx == tre_pkg::REG_COMPRESS) cfg_compress = value[0];
      else cfg_bpp = value[2:0];
      pend_cnt = 0;
      lead_px = '0;
      run_check = 1'b1;
      check_register(idx, value);
   endtask

   task automatic test_registers();
      check_register(tre_pkg::REG_COMPRESS, 32'(tre_pkg::COMPRESS_RESET));
      check_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RESET));
      set_register(tre_pkg::REG_BPP, 32'd0);
      set_register(tre_pkg::REG_BPP, 32'd7);
      set_register(tre_pkg::REG_COMPRESS, 32'd0);
      set_register(tre_pkg::REG_COMPRESS, 32'd1);
   endtask

   task automatic test_passthrough();
      set_register(tre_pkg::REG_COMPRESS, 32'd0);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RGBA));
      send_pixel(mk_px(8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
      send_pixel(mk_px(8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
      send_pixel(mk_px(8'ha5, 8'h5a, 8'h3c, 8'hc3), 1'b0);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RESET));
      send_pixel(mk_px(8'h12, 8'h34, 8'h56, 8'hff), 1'b1);
   endtask

   task automatic test_short_packets();
      tre_pkg::pixel_type a, b, c;
      set_register(tre_pkg::REG_COMPRESS, 32'd1);
      a = mk_px(8'h10, 8'h20, 8'h30, 8'h40);
      b = mk_px(8'hff, 8'h00, 8'hff, 8'h00);
      c = mk_px(8'h00, 8'hff, 8'h00, 8'hff);
      // single-pixel row
      send_pixel(a, 1'b1);
      // two different pixels close a raw packet at row end
      send_pixel(a, 1'b0);
      send_pixel(b, 1'b1);
      // run closed by row end
      send_pixel(c, 1'b0);
      send_pixel(c, 1'b0);
      send_pixel(c, 1'b1);
      // run closed by a different row-end pixel
      send_pixel(a, 1'b0);
      send_pixel(a, 1'b0);
      send_pixel(b, 1'b1);
      // raw packet stopped by its own first pixel, which starts a run
      send_pixel(a, 1'b0);
      send_pixel(b, 1'b0);
      send_pixel(c, 1'b0);
      send_pixel(a, 1'b0);
      send_pixel(a, 1'b1);
      // alpha alone differs: equal pixels in RGB mode
      send_pixel(mk_px(8'h77, 8'h88, 8'h99, 8'h00), 1'b0);
      send_pixel(mk_px(8'h77, 8'h88, 8'h99, 8'hff), 1'b1);
   endtask

   // Pending raw pixels are dropped by a register write
   task automatic test_config_drop();
      send_pixel(mk_px(8'h01, 8'h02, 8'h03, 8'h04), 1'b0);
      send_pixel(mk_px(8'h05, 8'h06, 8'h07, 8'h08), 1'b0);
      send_pixel(mk_px(8'h09, 8'h0a, 8'h0b, 8'h0c), 1'b0);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RGBA));
      send_pixel(mk_px(8'h0d, 8'h0e, 8'h0f, 8'h10), 1'b1);
   endtask

   // Packets at the length limit
   task automatic test_long_packets();
      tre_pkg::pixel_type lead;
      set_register(tre_pkg::REG_COMPRESS, 32'd1);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RGBA));
      // run hits the limit mid-row; next pixel opens a raw packet directly
      lead = rand_px();
      repeat (tre_pkg::MAX_PACKET_DEF) send_pixel(lead, 1'b0);
      send_pixel(lead, 1'b0);
      send_pixel(lead, 1'b1);
      // raw packet fills to the limit
      lead = rand_px();
      send_pixel(lead, 1'b0);
      repeat (tre_pkg::MAX_PACKET_DEF - 1) send_pixel(differ_px(lead), 1'b0);
      send_pixel(rand_px(), 1'b1);
      // raw packet one short of the limit meets its first pixel at row end
      lead = rand_px();
      send_pixel(lead, 1'b0);
      repeat (tre_pkg::FOLD_COUNT - 1) send_pixel(differ_px(lead), 1'b0);
      send_pixel(lead, 1'b1);
   endtask

   // Mostly well-formed rows built from runs and raw stretches, some noise
   task automatic test_random_rows(int count);
      tre_pkg::pixel_type pal [4];
      tre_pkg::pixel_type row_q[$];
      int sent;
      int len;
      int k;
      logic paused;
      sent = 0;
      paused = 1'b0;
      while (sent < count) begin
         for (k = 0; k < 4; k++) pal[k] = rand_px();
         pal[1] = {pal[1].alpha, pal[0][23:0]};
         row_q.delete();
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 4)) begin
               len = $urandom_range(1, 8);
               if ($urandom_range(0, 1) == 1) begin
                  k = $urandom_range(0, 3);
                  repeat (len) row_q.push_back(pal[k]);
               end else begin
                  repeat (len)
                     row_q.push_back(($urandom_range(0, 1) == 1) ? pal[$urandom_range(0, 3)]
                                                                 : rand_px());
               end
            end
            foreach (row_q[i]) send_pixel(row_q[i], i == row_q.size() - 1);
            sent += row_q.size();
         end else begin
            len = $urandom_range(1, 10);
            repeat (len)
               send_pixel(($urandom_range(0, 1) == 1) ? pal[$urandom_range(0, 3)] : rand_px(),
                          $urandom_range(0, 5) == 0);
            sent += len;
         end
         // hold off once until the encoder has caught up
         if (!paused && sent >= count / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // Result stall in random bursts
   always @(posedge clock) begin
      if (reset || !gaps_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, 24);
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted result with the oldest expected word
   always @(posedge clock) begin : check_results
      packet_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result arrived with none expected");
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("has_header", 8'(want.has_header), 8'(rsp_has_header));
            check_field("header_byte", want.header_byte, rsp_header_byte);
            check_field("pixel_count", 8'(want.pixel_count), 8'(rsp_pixel_count));
            check_field("first_blue", want.first_px.blue, rsp_first_blue);
            check_field("first_green", want.first_px.green, rsp_first_green);
            check_field("first_red", want.first_px.red, rsp_first_red);
            check_field("first_alpha", want.first_px.alpha, rsp_first_alpha);
            check_field("second_blue", want.second_px.blue, rsp_second_blue);
            check_field("second_green", want.second_px.green, rsp_second_green);
            check_field("second_red", want.second_px.red, rsp_second_red);
            check_field("second_alpha", want.second_px.alpha, rsp_second_alpha);
            check_field("packet_end", 8'(want.packet_end), 8'(rsp_packet_end));
         end
      end
   end

   // Watchdog on cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_registers();
      test_passthrough();
      test_short_packets();
      test_config_drop();
      test_long_packets();
      set_register(tre_pkg::REG_BPP, 32'd0);
      test_random_rows(25);
      set_register(tre_pkg::REG_COMPRESS, 32'd0);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RGBA));
      test_random_rows(15);
      set_register(tre_pkg::REG_COMPRESS, 32'd1);
      test_random_rows(40);
      set_register(tre_pkg::REG_BPP, 32'd7);
      test_random_rows(25);
      set_register(tre_pkg::REG_COMPRESS, 32'd0);
      set_register(tre_pkg::REG_BPP, 32'(tre_pkg::BPP_RESET));
      test_random_rows(15);
      // last stretch at full rate on both sides
      set_register(tre_pkg::REG_COMPRESS, 32'd1);
      gaps_on = 1'b0;
      test_random_rows(40);
      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
